// ----- src/hsfd_pkg.sv -----
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam logic [7:0] START_BYTE    = 8'hFC;
    localparam logic [7:0] TYPE_INFO     = 8'h62;
    localparam logic [7:0] TYPE_CONNECT  = 8'h7A;
    localparam logic [7:0] INFO_SETUP    = 8'h02;
    localparam logic [7:0] INFO_ROOM     = 8'h03;
    localparam logic [7:0] INFO_OPSTATE  = 8'h06;

    localparam logic [4:0] MIN_LEN_SETTINGS = 5'd12;
    localparam logic [4:0] MIN_LEN_ROOM     = 5'd7;
    localparam logic [4:0] MIN_LEN_STATUS   = 5'd5;

    localparam int DECODE_BYTES = 12;
    localparam int DATA_IDX_W   = $clog2(DECODE_BYTES);

    localparam logic [10:0] TEMP_OFFSET      = 11'd128;
    localparam logic [10:0] TARGET_LEGACY_HD = 11'd62;
    localparam logic [10:0] ROOM_LEGACY_HD   = 11'd20;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CONNECT = 2'd0,
        KIND_INFO    = 2'd1,
        KIND_OTHER   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SEL_NONE     = 2'd0,
        SEL_SETTINGS = 2'd1,
        SEL_ROOM     = 2'd2,
        SEL_STATUS   = 2'd3
    } t_info_sel;

    typedef struct packed {
        t_kind              kind;
        t_info_sel          sel;
        logic               power;
        logic [2:0]         mode;
        logic signed [10:0] target;
        logic [2:0]         fan;
        logic [2:0]         vane;
        logic signed [10:0] room;
        logic               running;
    } t_frame_rec;

    // the mode code is masked to three bits, so code eight never reaches the table
    function automatic logic [2:0] map_mode(input logic [2:0] code);
        logic [2:0] idx;
        case (code)
            3'd2:    idx = 3'd1;
            3'd3:    idx = 3'd2;
            3'd7:    idx = 3'd3;
            default: idx = 3'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [2:0] map_fan(input logic [7:0] code);
        logic [2:0] idx;
        case (code)
            8'h01:   idx = 3'd1;
            8'h02:   idx = 3'd2;
            8'h03:   idx = 3'd3;
            8'h05:   idx = 3'd4;
            8'h06:   idx = 3'd5;
            default: idx = 3'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [2:0] map_vane(input logic [7:0] code);
        logic [2:0] idx;
        if (code <= 8'h05) begin
            idx = code[2:0];
        end else if (code == 8'h07) begin
            idx = 3'd6;
        end else begin
            idx = 3'd0;
        end
        return idx;
    endfunction

endpackage

// ----- src/hsfd_ifs.sv -----
`timescale 1ns / 1ps

interface hsfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
    modport monitor (input valid, input rx_byte, input ready);
endinterface

interface hsfd_st_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic               link_up;
    logic               power_state;
    logic [2:0]         mode_index;
    logic signed [10:0] target_half_deg;
    logic [2:0]         fan_index;
    logic [2:0]         vane_index;
    logic signed [10:0] room_half_deg;
    logic               running;
    logic               changed;

    modport source (
        output valid, frame_kind, link_up, power_state, mode_index, target_half_deg,
        output fan_index, vane_index, room_half_deg, running, changed,
        input ready
    );
    modport sink (
        input valid, frame_kind, link_up, power_state, mode_index, target_half_deg,
        input fan_index, vane_index, room_half_deg, running, changed,
        output ready
    );
    modport monitor (
        input valid, frame_kind, link_up, power_state, mode_index, target_half_deg,
        input fan_index, vane_index, room_half_deg, running, changed,
        input ready
    );
endinterface

// ----- src/hsfd_front.sv -----
`timescale 1ns / 1ps

module hsfd_front
    import hsfd_pkg::*;
#(
    parameter int MAX_DATA_LEN = 22
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsfd_rx_if.sink    i_rx,
    output logic       o_push_valid,
    output t_frame_rec o_push_rec,
    input  logic       i_push_ready
);

    localparam logic [7:0] MAX_LEN_B = 8'(MAX_DATA_LEN);

    t_phase     r_phase, n_phase;
    logic [1:0] r_hdr_cnt, n_hdr_cnt;
    logic [7:0] r_type, n_type;
    logic [4:0] r_len, n_len;
    logic [4:0] r_dcnt, n_dcnt;
    logic [7:0] r_data [DECODE_BYTES];

    logic       accept;
    logic [4:0] dcnt_inc;
    logic [7:0] b;

    assign i_rx.ready   = i_push_ready;
    assign accept       = i_rx.valid && i_push_ready;
    assign b            = i_rx.rx_byte;
    assign dcnt_inc     = r_dcnt + 5'd1;
    assign o_push_valid = accept && (r_phase == PH_CHECK);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_type    = r_type;
        n_len     = r_len;
        n_dcnt    = r_dcnt;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (b == START_BYTE) begin
                        n_hdr_cnt = 2'd0;
                        n_dcnt    = 5'd0;
                        n_phase   = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (r_hdr_cnt == 2'd0) begin
                        n_type = b;
                    end
                    if (r_hdr_cnt == 2'd3) begin
                        n_hdr_cnt = 2'd0;
                        if (b > MAX_LEN_B) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_len   = b[4:0];
                            n_dcnt  = 5'd0;
                            n_phase = (b[4:0] == 5'd0) ? PH_CHECK : PH_DATA;
                        end
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end
                end
                PH_DATA: begin
                    n_dcnt = dcnt_inc;
                    if (dcnt_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_cnt <= 2'd0;
            r_type    <= 8'd0;
            r_len     <= 5'd0;
            r_dcnt    <= 5'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_type    <= n_type;
            r_len     <= n_len;
            r_dcnt    <= n_dcnt;
        end
    end

    // only the leading bytes are ever decoded; later data bytes are dropped
    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_HUNT) && (b == START_BYTE)) begin
            for (int i = 0; i < DECODE_BYTES; i++) begin
                r_data[i] <= 8'd0;
            end
        end else if (accept && (r_phase == PH_DATA) && (r_dcnt < 5'(DECODE_BYTES))) begin
            r_data[r_dcnt[DATA_IDX_W-1:0]] <= b;
        end
    end

    always_comb begin
        o_push_rec = '0;
        if (r_type == TYPE_CONNECT) begin
            o_push_rec.kind = KIND_CONNECT;
        end else if (r_type == TYPE_INFO) begin
            o_push_rec.kind = KIND_INFO;
        end else begin
            o_push_rec.kind = KIND_OTHER;
        end

        o_push_rec.sel = SEL_NONE;
        if (r_type == TYPE_INFO) begin
            if ((r_data[0] == INFO_SETUP) && (r_len >= MIN_LEN_SETTINGS)) begin
                o_push_rec.sel = SEL_SETTINGS;
            end else if ((r_data[0] == INFO_ROOM) && (r_len >= MIN_LEN_ROOM)) begin
                o_push_rec.sel = SEL_ROOM;
            end else if ((r_data[0] == INFO_OPSTATE) && (r_len >= MIN_LEN_STATUS)) begin
                o_push_rec.sel = SEL_STATUS;
            end
        end

        o_push_rec.power = (r_data[3] == 8'h01);
        o_push_rec.mode  = map_mode(r_data[4][2:0]);
        o_push_rec.fan   = map_fan(r_data[6]);
        o_push_rec.vane  = map_vane(r_data[7]);

        // zero in the half-degree byte selects the legacy whole-degree encoding
        if (r_data[11] != 8'd0) begin
            o_push_rec.target = {3'b000, r_data[11]} - TEMP_OFFSET;
        end else begin
            o_push_rec.target = TARGET_LEGACY_HD - {2'b00, r_data[5], 1'b0};
        end
        if (r_data[6] != 8'd0) begin
            o_push_rec.room = {3'b000, r_data[6]} - TEMP_OFFSET;
        end else begin
            o_push_rec.room = ROOM_LEGACY_HD + {2'b00, r_data[3], 1'b0};
        end

        o_push_rec.running = (r_data[4] != 8'd0);
    end

endmodule

// ----- src/hsfd_queue.sv -----
`timescale 1ns / 1ps

module hsfd_queue
    import hsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_push_rec,
    output logic       o_push_ready,
    output logic       o_valid,
    output t_frame_rec o_rec,
    input  logic       i_pop
);

    t_frame_rec r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_rec        = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/hsfd_back.sv -----
`timescale 1ns / 1ps

module hsfd_back
    import hsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_frame_rec i_rec,
    output logic       o_pop,
    hsfd_st_if.source  o_st
);

    logic               r_out_valid;
    t_kind              r_kind;
    logic               r_chg;
    logic               r_link, n_link;
    logic               r_power, n_power;
    logic [2:0]         r_mode, n_mode;
    logic signed [10:0] r_target, n_target;
    logic [2:0]         r_fan, n_fan;
    logic [2:0]         r_vane, n_vane;
    logic signed [10:0] r_room, n_room;
    logic               r_run, n_run;
    logic               n_chg;

    assign o_pop = i_valid && (!r_out_valid || o_st.ready);

    always_comb begin
        n_link   = r_link;
        n_power  = r_power;
        n_mode   = r_mode;
        n_target = r_target;
        n_fan    = r_fan;
        n_vane   = r_vane;
        n_room   = r_room;
        n_run    = r_run;
        n_chg    = 1'b0;
        unique case (i_rec.kind)
            KIND_CONNECT: begin
                n_link = 1'b1;
                n_chg  = !r_link;
            end
            KIND_INFO: begin
                unique case (i_rec.sel)
                    SEL_SETTINGS: begin
                        n_power  = i_rec.power;
                        n_mode   = i_rec.mode;
                        n_target = i_rec.target;
                        n_fan    = i_rec.fan;
                        n_vane   = i_rec.vane;
                        n_chg    = (i_rec.power != r_power) || (i_rec.mode != r_mode)
                                || (i_rec.target != r_target) || (i_rec.fan != r_fan)
                                || (i_rec.vane != r_vane);
                    end
                    SEL_ROOM: begin
                        n_room = i_rec.room;
                        n_chg  = (i_rec.room != r_room);
                    end
                    SEL_STATUS: begin
                        n_run = i_rec.running;
                        n_chg = (i_rec.running != r_run);
                    end
                    default: begin
                        n_chg = 1'b0;
                    end
                endcase
            end
            default: begin
                n_chg = 1'b0;
            end
        endcase
    end

    // kept status only moves when a new result is loaded, so it doubles as the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_link      <= 1'b0;
            r_power     <= 1'b0;
            r_mode      <= 3'd0;
            r_target    <= 11'sd0;
            r_fan       <= 3'd0;
            r_vane      <= 3'd0;
            r_room      <= 11'sd0;
            r_run       <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
            r_link      <= n_link;
            r_power     <= n_power;
            r_mode      <= n_mode;
            r_target    <= n_target;
            r_fan       <= n_fan;
            r_vane      <= n_vane;
            r_room      <= n_room;
            r_run       <= n_run;
        end else if (o_st.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_rec.kind;
            r_chg  <= n_chg;
        end
    end

    assign o_st.valid           = r_out_valid;
    assign o_st.frame_kind      = r_kind;
    assign o_st.link_up         = r_link;
    assign o_st.power_state     = r_power;
    assign o_st.mode_index      = r_mode;
    assign o_st.target_half_deg = r_target;
    assign o_st.fan_index       = r_fan;
    assign o_st.vane_index      = r_vane;
    assign o_st.room_half_deg   = r_room;
    assign o_st.running         = r_run;
    assign o_st.changed         = r_chg;

endmodule

// ----- src/hvac_serial_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// throughput: one received byte per cycle, limited only by the two-entry frame queue
// result path: the checksum byte transfer writes the frame record into the queue, and the result register loads it
// from the queue head once the output slot is free or taken; non-result bytes only advance the front parser
// and produce nothing; reset: synchronous active low, parser returns to hunting and kept status clears to zero

module hvac_serial_frame_decoder_unit
    import hsfd_pkg::*;
#(
    parameter int MAX_DATA_LEN = 22
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsfd_rx_if.sink   i_rx,
    hsfd_st_if.source o_st
);

    logic       push_valid;
    logic       push_ready;
    t_frame_rec push_rec;
    logic       q_valid;
    t_frame_rec q_rec;
    logic       q_pop;

    hsfd_front #(
        .MAX_DATA_LEN(MAX_DATA_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .o_push_valid(push_valid),
        .o_push_rec  (push_rec),
        .i_push_ready(push_ready)
    );

    hsfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_rec  (push_rec),
        .o_push_ready(push_ready),
        .o_valid     (q_valid),
        .o_rec       (q_rec),
        .i_pop       (q_pop)
    );

    hsfd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_rec  (q_rec),
        .o_pop  (q_pop),
        .o_st   (o_st)
    );

endmodule

// ----- src/hsfd_checker.sv -----
`timescale 1ns / 1ps

module hsfd_checker
    import hsfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [1:0]         i_frame_kind,
    input logic               i_link_up,
    input logic [2:0]         i_mode,
    input logic signed [10:0] i_target,
    input logic [2:0]         i_fan,
    input logic [2:0]         i_vane,
    input logic               i_changed
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_frame_kind)
            && $stable(i_changed) && $stable(i_target)))
        else $error("stalled status transfer not held");

    a_link_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_link_up |=> i_link_up)
        else $error("link flag dropped");

    a_connect_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_frame_kind == KIND_CONNECT)) |-> i_link_up)
        else $error("connect acknowledge without link flag");

    a_other_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_frame_kind == KIND_OTHER)) |-> !i_changed)
        else $error("unknown frame type reported a change");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_mode <= 3'd4) && (i_fan <= 3'd5) && (i_vane <= 3'd6)))
        else $error("status index out of range");

endmodule

bind hvac_serial_frame_decoder_unit hsfd_checker u_hsfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_st.valid),
    .i_ready     (o_st.ready),
    .i_frame_kind(o_st.frame_kind),
    .i_link_up   (o_st.link_up),
    .i_mode      (o_st.mode_index),
    .i_target    (o_st.target_half_deg),
    .i_fan       (o_st.fan_index),
    .i_vane      (o_st.vane_index),
    .i_changed   (o_st.changed)
);

// ----- test/tb_hvac_serial_frame_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_hvac_serial_frame_decoder_unit;
    import hsfd_pkg::*;

    localparam int MAX_LEN = 22;
    localparam int TOTAL_BYTES = 1900;
    localparam logic [8:0] HOLD_MARK = 9'h100;

    typedef struct packed {
        t_kind              kind;
        logic               link;
        logic               power;
        logic [2:0]         mode;
        logic signed [10:0] target;
        logic [2:0]         fan;
        logic [2:0]         vane;
        logic signed [10:0] room;
        logic               run;
        logic               chg;
    } t_unit_status;

    logic i_clk;
    logic i_rst_n;

    hsfd_rx_if rx_bus ();
    hsfd_st_if st_bus ();

    hvac_serial_frame_decoder_unit #(
        .MAX_DATA_LEN(MAX_LEN)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_bus),
        .o_st   (st_bus)
    );

    // bit 8 set marks a pause until all pending status results are back
    logic [8:0]   rx_pending[$];
    logic [8:0]   next_entry;
    t_unit_status status_expected[$];
    logic [7:0]   payload[32];

    int mismatches;
    int bytes_sent;
    int results_seen;
    int kinds_seen[3];
    logic calm;

    // parser copy
    t_phase     p_phase;
    logic [1:0] p_hdr_idx;
    logic [7:0] p_type;
    logic [4:0] p_len;
    logic [4:0] p_idx;
    logic [7:0] p_data[MAX_LEN];

    // kept status copy
    logic k_link;
    logic k_power;
    logic [2:0] k_mode;
    int   k_target;
    logic [2:0] k_fan;
    logic [2:0] k_vane;
    int   k_room;
    logic k_run;

    assign calm = (bytes_sent >= 700) && (bytes_sent < 1000);

    function automatic logic [2:0] mode_slot(input logic [2:0] code);
        case (code)
            3'd2:    return 3'd1;
            3'd3:    return 3'd2;
            3'd7:    return 3'd3;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] fan_slot(input logic [7:0] code);
        case (code)
            8'h01:   return 3'd1;
            8'h02:   return 3'd2;
            8'h03:   return 3'd3;
            8'h05:   return 3'd4;
            8'h06:   return 3'd5;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] vane_slot(input logic [7:0] code);
        if (code <= 8'h05) begin
            return code[2:0];
        end else if (code == 8'h07) begin
            return 3'd6;
        end
        return 3'd0;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        t_unit_status s;
        logic chg;
        logic n_power;
        logic [2:0] n_mode;
        logic [2:0] n_fan;
        logic [2:0] n_vane;
        int n_temp;
        chg = 1'b0;
        case (p_phase)
            PH_HUNT: begin
                if (b == START_BYTE) begin
                    for (int i = 0; i < MAX_LEN; i++) p_data[i] = 8'h00;
                    p_hdr_idx = 2'd0;
                    p_idx = 5'd0;
                    p_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (p_hdr_idx == 2'd0) p_type = b;
                if (p_hdr_idx == 2'd3) begin
                    p_hdr_idx = 2'd0;
                    if (b > MAX_LEN) begin
                        p_phase = PH_HUNT;
                    end else begin
                        p_len = b[4:0];
                        p_idx = 5'd0;
                        p_phase = (p_len == 5'd0) ? PH_CHECK : PH_DATA;
                    end
                end else begin
                    p_hdr_idx = p_hdr_idx + 2'd1;
                end
            end
            PH_DATA: begin
                if (p_idx < MAX_LEN) p_data[p_idx] = b;
                p_idx = p_idx + 5'd1;
                if (p_idx >= p_len) p_phase = PH_CHECK;
            end
            default: begin
                p_phase = PH_HUNT;
                if (p_type == TYPE_CONNECT) begin
                    s.kind = KIND_CONNECT;
                    if (!k_link) begin
                        k_link = 1'b1;
                        chg = 1'b1;
                    end
                end else if (p_type == TYPE_INFO) begin
                    s.kind = KIND_INFO;
                    if (p_data[0] == INFO_SETUP && p_len >= MIN_LEN_SETTINGS) begin
                        n_power = (p_data[3] == 8'h01);
                        n_mode = mode_slot(p_data[4][2:0]);
                        // explicit half-degree byte, else legacy whole-degree code
                        n_temp = (p_data[11] != 8'h00) ? int'(p_data[11]) - 128
                                                       : 62 - 2 * int'(p_data[5]);
                        n_fan = fan_slot(p_data[6]);
                        n_vane = vane_slot(p_data[7]);
                        if (n_power != k_power) begin k_power = n_power; chg = 1'b1; end
                        if (n_mode != k_mode) begin k_mode = n_mode; chg = 1'b1; end
                        if (n_temp != k_target) begin k_target = n_temp; chg = 1'b1; end
                        if (n_fan != k_fan) begin k_fan = n_fan; chg = 1'b1; end
                        if (n_vane != k_vane) begin k_vane = n_vane; chg = 1'b1; end
                    end else if (p_data[0] == INFO_ROOM && p_len >= MIN_LEN_ROOM) begin
                        n_temp = (p_data[6] != 8'h00) ? int'(p_data[6]) - 128
                                                      : 20 + 2 * int'(p_data[3]);
                        if (n_temp != k_room) begin k_room = n_temp; chg = 1'b1; end
                    end else if (p_data[0] == INFO_OPSTATE && p_len >= MIN_LEN_STATUS) begin
                        if ((p_data[4] != 8'h00) != k_run) begin
                            k_run = (p_data[4] != 8'h00);
                            chg = 1'b1;
                        end
                    end
                end else begin
                    s.kind = KIND_OTHER;
                end
                s.link = k_link;
                s.power = k_power;
                s.mode = k_mode;
                s.target = k_target[10:0];
                s.fan = k_fan;
                s.vane = k_vane;
                s.room = k_room[10:0];
                s.run = k_run;
                s.chg = chg;
                status_expected.push_back(s);
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches = mismatches + 1;
        $display("%0t: %0s differs on status result %0d: got %0d, want %0d",
                 $realtime, what, results_seen, got, want);
    endtask

    task automatic check_status();
        t_unit_status w;
        if (status_expected.size() == 0) begin
            note_mismatch("unexpected transfer", int'(st_bus.frame_kind), -1);
        end else begin
            w = status_expected.pop_front();
            kinds_seen[w.kind] = kinds_seen[w.kind] + 1;
            if (st_bus.frame_kind !== w.kind)
                note_mismatch("frame_kind", int'(st_bus.frame_kind), int'(w.kind));
            if (st_bus.link_up !== w.link)
                note_mismatch("link_up", int'(st_bus.link_up), int'(w.link));
            if (st_bus.power_state !== w.power)
                note_mismatch("power_state", int'(st_bus.power_state), int'(w.power));
            if (st_bus.mode_index !== w.mode)
                note_mismatch("mode_index", int'(st_bus.mode_index), int'(w.mode));
            if (st_bus.target_half_deg !== w.target)
                note_mismatch("target_half_deg", int'(st_bus.target_half_deg),
                              int'(w.target));
            if (st_bus.fan_index !== w.fan)
                note_mismatch("fan_index", int'(st_bus.fan_index), int'(w.fan));
            if (st_bus.vane_index !== w.vane)
                note_mismatch("vane_index", int'(st_bus.vane_index), int'(w.vane));
            if (st_bus.room_half_deg !== w.room)
                note_mismatch("room_half_deg", int'(st_bus.room_half_deg), int'(w.room));
            if (st_bus.running !== w.run)
                note_mismatch("running", int'(st_bus.running), int'(w.run));
            if (st_bus.changed !== w.chg)
                note_mismatch("changed", int'(st_bus.changed), int'(w.chg));
        end
        results_seen = results_seen + 1;
    endtask

    task automatic push_rx(input logic [7:0] b);
        rx_pending.push_back({1'b0, b});
    endtask

    // header, then data from payload and a random checksum unless the length is too big
    task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] len);
        push_rx(START_BYTE);
        push_rx(ftype);
        push_rx(8'($urandom_range(255)));
        push_rx(8'($urandom_range(255)));
        push_rx(len);
        if (len <= MAX_LEN) begin
            for (int i = 0; i < len; i++) push_rx(payload[i]);
            push_rx(8'($urandom_range(255)));
        end
        foreach (payload[i]) payload[i] = 8'h00;
    endtask

    task automatic queue_info_frame();
        int pick;
        logic [7:0] len;
        pick = $urandom_range(9);
        foreach (payload[i]) payload[i] = 8'($urandom_range(255));
        case (pick)
            0, 1, 2, 3: begin
                payload[0] = INFO_SETUP;
                payload[3] = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(1));
                case ($urandom_range(5))
                    0: payload[4] = 8'h01;
                    1: payload[4] = 8'h02;
                    2: payload[4] = 8'h03;
                    3: payload[4] = 8'h07;
                    4: payload[4] = 8'h08;
                    default: payload[4] = 8'($urandom_range(255));
                endcase
                payload[5] = 8'(($urandom_range(1) == 0) ? $urandom_range(16, 31)
                                                         : $urandom_range(255));
                payload[6] = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(6));
                payload[7] = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(8));
                case ($urandom_range(3))
                    0: payload[11] = 8'h00;
                    1: payload[11] = 8'd172;
                    2: payload[11] = 8'd174;
                    default: payload[11] = 8'($urandom_range(255));
                endcase
                len = 8'(($urandom_range(9) == 0) ? $urandom_range(11)
                                                  : $urandom_range(12, MAX_LEN));
            end
            4, 5: begin
                payload[0] = INFO_ROOM;
                payload[3] = 8'(($urandom_range(1) == 0) ? $urandom_range(10, 20)
                                                         : $urandom_range(255));
                payload[6] = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255));
                len = 8'(($urandom_range(9) == 0) ? $urandom_range(6)
                                                  : $urandom_range(7, MAX_LEN));
            end
            6, 7: begin
                payload[0] = INFO_OPSTATE;
                payload[4] = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(1));
                len = 8'(($urandom_range(9) == 0) ? $urandom_range(4)
                                                  : $urandom_range(5, MAX_LEN));
            end
            default: begin
                if (pick == 8) payload[0] = 8'($urandom_range(255));
                len = 8'($urandom_range(MAX_LEN));
            end
        endcase
        queue_frame(TYPE_INFO, len);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // byte source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_bus.valid <= 1'b0;
        end else if (!rx_bus.valid || rx_bus.ready) begin
            if (rx_pending.size() != 0 && rx_pending[0][8]) begin
                if (!rx_bus.valid && status_expected.size() == 0) rx_pending.delete(0);
                rx_bus.valid <= 1'b0;
            end else if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
                next_entry = rx_pending.pop_front();
                rx_bus.valid <= 1'b1;
                rx_bus.rx_byte <= next_entry[7:0];
            end else begin
                rx_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            st_bus.ready <= 1'b0;
        end else begin
            st_bus.ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // transfer monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (st_bus.valid && st_bus.ready) check_status();
            if (rx_bus.valid && rx_bus.ready) begin
                parse_rx_byte(rx_bus.rx_byte);
                bytes_sent = bytes_sent + 1;
            end
        end
    end

    initial begin
        int roll;
        logic [7:0] ftype;
        rx_bus.valid = 1'b0;
        rx_bus.rx_byte = 8'h00;
        st_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        mismatches = 0;
        bytes_sent = 0;
        results_seen = 0;
        kinds_seen[0] = 0;
        kinds_seen[1] = 0;
        kinds_seen[2] = 0;
        p_phase = PH_HUNT;
        p_hdr_idx = 2'd0;
        p_type = 8'h00;
        p_len = 5'd0;
        p_idx = 5'd0;
        for (int i = 0; i < MAX_LEN; i++) p_data[i] = 8'h00;
        k_link = 1'b0;
        k_power = 1'b0;
        k_mode = 3'd0;
        k_target = 0;
        k_fan = 3'd0;
        k_vane = 3'd0;
        k_room = 0;
        k_run = 1'b0;
        foreach (payload[i]) payload[i] = 8'h00;

        // directed: stray bytes while hunting, connect ack with zero length and repeated
        push_rx(8'h00);
        push_rx(8'hFF);
        queue_frame(TYPE_CONNECT, 8'd0);
        queue_frame(TYPE_CONNECT, 8'd1);
        // settings at minimum length, legacy target, top fan and swing vane
        payload[0] = INFO_SETUP;
        payload[3] = 8'h01;
        payload[4] = 8'h03;
        payload[6] = 8'h06;
        payload[7] = 8'h07;
        queue_frame(TYPE_INFO, 8'(MIN_LEN_SETTINGS));
        // settings at full length, unknown fan and vane codes, masked mode, extreme target
        payload[0] = INFO_SETUP;
        payload[4] = 8'h0A;
        payload[6] = 8'h04;
        payload[7] = 8'h06;
        payload[11] = 8'hFF;
        for (int i = 12; i < MAX_LEN; i++) payload[i] = 8'hFF;
        queue_frame(TYPE_INFO, 8'(MAX_LEN));
        // short settings, then room both ways, status and short status
        payload[0] = INFO_SETUP;
        payload[3] = 8'h01;
        queue_frame(TYPE_INFO, 8'(MIN_LEN_SETTINGS - 5'd1));
        payload[0] = INFO_ROOM;
        payload[3] = 8'hFF;
        queue_frame(TYPE_INFO, 8'(MIN_LEN_ROOM));
        payload[0] = INFO_ROOM;
        payload[6] = 8'h01;
        queue_frame(TYPE_INFO, 8'(MIN_LEN_ROOM));
        payload[0] = INFO_OPSTATE;
        payload[4] = 8'h80;
        queue_frame(TYPE_INFO, 8'(MIN_LEN_STATUS));
        payload[0] = INFO_OPSTATE;
        queue_frame(TYPE_INFO, 8'(MIN_LEN_STATUS - 5'd1));
        rx_pending.push_back(HOLD_MARK);
        // unknown info kind, other type, oversized lengths, start byte inside a frame
        payload[0] = 8'h01;
        queue_frame(TYPE_INFO, 8'(MAX_LEN));
        queue_frame(8'h00, 8'd2);
        queue_frame(TYPE_INFO, 8'(MAX_LEN + 1));
        queue_frame(START_BYTE, 8'd255);
        for (int i = 0; i < 5; i++) payload[i] = START_BYTE;
        queue_frame(START_BYTE, 8'd5);
        for (int i = 0; i < 5; i++) payload[i] = START_BYTE;
        queue_frame(TYPE_INFO, 8'd5);

        while (rx_pending.size() < TOTAL_BYTES) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 5))
                    push_rx(($urandom_range(9) == 0) ? START_BYTE : 8'($urandom_range(255)));
            end else if (roll < 18) begin
                queue_frame(TYPE_CONNECT, 8'($urandom_range(3)));
            end else if (roll < 25) begin
                ftype = 8'($urandom_range(255));
                if (ftype == TYPE_INFO || ftype == TYPE_CONNECT) ftype = ~ftype;
                foreach (payload[i]) payload[i] = 8'($urandom_range(255));
                queue_frame(ftype, 8'($urandom_range(MAX_LEN)));
            end else if (roll < 31) begin
                queue_frame(($urandom_range(1) == 0) ? TYPE_INFO : 8'($urandom_range(255)),
                            8'($urandom_range(MAX_LEN + 1, 255)));
            end else begin
                queue_info_frame();
            end
            if ($urandom_range(149) == 0) rx_pending.push_back(HOLD_MARK);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || rx_bus.valid) @(posedge i_clk);
        while (status_expected.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d received bytes and %0d status results", bytes_sent, results_seen);
        $display("results by frame: %0d connect ack, %0d info, %0d other",
                 kinds_seen[0], kinds_seen[1], kinds_seen[2]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("run timed out with %0d status results pending", status_expected.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
src/hsfd_pkg.sv
src/hsfd_ifs.sv
src/hsfd_front.sv
src/hsfd_queue.sv
src/hsfd_back.sv
src/hvac_serial_frame_decoder_unit.sv
src/hsfd_checker.sv
test/tb_hvac_serial_frame_decoder_unit.sv
